// File: rtl/lfu_pkg.sv
`timescale 1ns / 1ps
// Shared widths, reset values and compare-unit flag type for the LFU cache table.
package lfu_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef struct packed {
		logic key_eq;
		logic better;
		logic younger;
	} eval_flags_t;

endpackage

// File: rtl/lfu_cache_table.sv
`timescale 1ns / 1ps
// LFU cache table top level: sequencer, entry state and result register.
//
// channel   ports                                         handshake
// config    cfg_write, capacity_in_use                    write when cfg_write high
// request   start, busy, operation, lookup_key, store_value  taken when start & !busy
// result    done, hit, read_value                         one-cycle strobe on done
//
// A scan reads one entry per cycle through the shared compare unit.
// A decide state follows; done rises the cycle after it.
// An access that changes state adds an aging sweep and a write state before busy falls;
// a get miss or ignored put returns to idle right after the decide state.
// Reset clears valid bits and occupancy and sets capacity to 16; no clearing pass is needed.
// The receiver cannot stall; done is never held.
module lfu_cache_table #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [lfu_pkg::CAP_W-1:0] capacity_in_use,
	input  logic                      start,
	input  logic                      operation,
	input  logic [lfu_pkg::KEY_W-1:0] lookup_key,
	input  logic [lfu_pkg::VAL_W-1:0] store_value,
	output logic                      busy,
	output logic                      done,
	output logic                      hit,
	output logic [lfu_pkg::VAL_W-1:0] read_value
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int KW = lfu_pkg::KEY_W;
	localparam int VW = lfu_pkg::VAL_W;
	localparam int RW = KW + VW + COUNT_BITS + IW;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_AGE    = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;

	logic [2:0]                state_q;
	logic [CW-1:0]             cnt_q;
	logic [lfu_pkg::CAP_W-1:0] capacity_q;
	logic [ENTRIES-1:0]        valid_q;
	logic [CW-1:0]             occ_q;

	logic                      op_q;
	logic [KW-1:0]             key_q;
	logic [VW-1:0]             val_q;

	logic                      rd_vld_s1;
	logic [IW-1:0]             rd_idx_s1;
	logic [RW-1:0]             rd_data;

	logic                      hit_q;
	logic [IW-1:0]             h_idx_q;
	logic [VW-1:0]             h_val_q;
	logic [COUNT_BITS-1:0]     h_cnt_q;
	logic [IW-1:0]             h_rank_q;
	logic                      vic_found_q;
	logic [IW-1:0]             vic_idx_q;
	logic [COUNT_BITS-1:0]     vic_cnt_q;
	logic [IW-1:0]             vic_rank_q;
	logic                      free_found_q;
	logic [IW-1:0]             free_idx_q;

	logic [IW-1:0]             slot_q;
	logic                      age_all_q;
	logic [IW-1:0]             limit_q;
	logic [COUNT_BITS-1:0]     new_cnt_q;
	logic [VW-1:0]             new_val_q;
	logic                      grow_q;

	logic                      done_q;
	logic                      hit_out_q;
	logic [VW-1:0]             rval_q;

	logic [KW-1:0]             rec_key;
	logic [VW-1:0]             rec_val;
	logic [COUNT_BITS-1:0]     rec_cnt;
	logic [IW-1:0]             rec_rank;
	lfu_pkg::eval_flags_t      flags;
	logic [IW-1:0]             rank_inc;

	logic                      accept;
	logic                      rd_en;
	logic                      scan_vld;
	logic                      age_vld;
	logic                      mem_we;
	logic [IW-1:0]             mem_waddr;
	logic [RW-1:0]             mem_wdata;

	logic [31:0]               cap_eff;
	logic                      full;
	logic [COUNT_BITS-1:0]     cnt_inc;
	logic                      d_upd;
	logic [IW-1:0]             d_slot;
	logic                      d_all;
	logic [IW-1:0]             d_limit;
	logic [COUNT_BITS-1:0]     d_cnt;
	logic [VW-1:0]             d_val;
	logic                      d_grow;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign rd_en    = ((state_q == ST_SCAN) || (state_q == ST_AGE)) && (cnt_q != CW'(ENTRIES));
	assign scan_vld = rd_vld_s1 && (state_q == ST_SCAN);
	assign age_vld  = rd_vld_s1 && (state_q == ST_AGE);

	assign rec_key  = rd_data[RW-1 -: KW];
	assign rec_val  = rd_data[RW-KW-1 -: VW];
	assign rec_cnt  = rd_data[IW +: COUNT_BITS];
	assign rec_rank = rd_data[IW-1:0];

	lfu_mem #(
		.DEPTH (ENTRIES),
		.WIDTH (RW),
		.AW    (IW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (rd_en),
		.raddr   (cnt_q[IW-1:0]),
		.rdata_q (rd_data)
	);

	lfu_eval #(
		.COUNT_BITS (COUNT_BITS),
		.RANK_W     (IW)
	) u_eval (
		.rec_key   (rec_key),
		.key       (key_q),
		.rec_cnt   (rec_cnt),
		.best_cnt  (vic_cnt_q),
		.rec_rank  (rec_rank),
		.best_rank (vic_rank_q),
		.limit     (limit_q),
		.age_all   (age_all_q),
		.flags     (flags),
		.rank_inc  (rank_inc)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = {rec_key, rec_val, rec_cnt, rank_inc};
		if (age_vld && valid_q[rd_idx_s1] && (rd_idx_s1 != slot_q) && flags.younger) begin
			mem_we = 1'b1;
		end
		if (state_q == ST_WRITE) begin
			mem_we    = 1'b1;
			mem_waddr = slot_q;
			mem_wdata = {key_q, new_val_q, new_cnt_q, IW'(0)};
		end
	end

	always_comb begin
		cap_eff = (32'(capacity_q) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(capacity_q);
		full    = (32'(occ_q) >= cap_eff);
		cnt_inc = (h_cnt_q == '1) ? h_cnt_q : h_cnt_q + COUNT_BITS'(1);
		d_upd   = 1'b0;
		d_slot  = h_idx_q;
		d_all   = 1'b0;
		d_limit = h_rank_q;
		d_cnt   = cnt_inc;
		d_val   = (op_q == OP_PUT) ? val_q : h_val_q;
		d_grow  = 1'b0;
		if (hit_q) begin
			d_upd = (op_q == OP_GET) || (cap_eff != 32'd0);
		end else if ((op_q == OP_PUT) && (cap_eff != 32'd0)) begin
			d_cnt = COUNT_BITS'(1);
			if (!full && free_found_q) begin
				d_upd  = 1'b1;
				d_slot = free_idx_q;
				d_all  = 1'b1;
				d_grow = 1'b1;
			end else if (vic_found_q) begin
				d_upd   = 1'b1;
				d_slot  = vic_idx_q;
				d_limit = vic_rank_q;
			end
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			capacity_q   <= lfu_pkg::CAP_RESET;
			valid_q      <= '0;
			occ_q        <= '0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			done_q    <= 1'b0;
			if (cfg_write) begin
				capacity_q <= capacity_in_use;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_SCAN;
						cnt_q        <= '0;
						hit_q        <= 1'b0;
						vic_found_q  <= 1'b0;
						free_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						state_q <= ST_DECIDE;
					end
					if (scan_vld) begin
						if (valid_q[rd_idx_s1]) begin
							if (flags.key_eq && !hit_q) begin
								hit_q <= 1'b1;
							end
							if (!vic_found_q || flags.better) begin
								vic_found_q <= 1'b1;
							end
						end else if (!free_found_q) begin
							free_found_q <= 1'b1;
						end
					end
				end
				ST_DECIDE: begin
					done_q  <= 1'b1;
					cnt_q   <= '0;
					state_q <= d_upd ? ST_AGE : ST_IDLE;
				end
				ST_AGE: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					valid_q[slot_q] <= 1'b1;
					if (grow_q) begin
						occ_q <= occ_q + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request, scan and decide payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IW-1:0];
		if (accept) begin
			op_q  <= operation;
			key_q <= lookup_key;
			val_q <= store_value;
		end
		if (scan_vld) begin
			if (valid_q[rd_idx_s1]) begin
				if (flags.key_eq && !hit_q) begin
					h_idx_q  <= rd_idx_s1;
					h_val_q  <= rec_val;
					h_cnt_q  <= rec_cnt;
					h_rank_q <= rec_rank;
				end
				if (!vic_found_q || flags.better) begin
					vic_idx_q  <= rd_idx_s1;
					vic_cnt_q  <= rec_cnt;
					vic_rank_q <= rec_rank;
				end
			end else if (!free_found_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		if (state_q == ST_DECIDE) begin
			slot_q    <= d_slot;
			age_all_q <= d_all;
			limit_q   <= d_limit;
			new_cnt_q <= d_cnt;
			new_val_q <= d_val;
			grow_q    <= d_grow;
			hit_out_q <= hit_q;
			rval_q    <= ((op_q == OP_GET) && hit_q) ? h_val_q : '0;
		end
	end

	assign done       = done_q;
	assign hit        = hit_out_q;
	assign read_value = rval_q;

`ifndef SYNTHESIS
	a_done_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DECIDE))
		else $error("result word without decide cycle");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(ENTRIES))
		else $error("occupancy above table size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == ST_AGE) || (state_q == ST_WRITE)))
		else $error("table write outside update phase");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'($countones(valid_q)) == 32'(occ_q))
		else $error("occupancy disagrees with valid bits");
`endif

endmodule

// File: rtl/lfu_mem.sv
`timescale 1ns / 1ps
// Entry record memory: one write port, one registered read port.
module lfu_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 84,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/lfu_eval.sv
`timescale 1ns / 1ps
// Shared compare unit: key match, victim ordering, aging test and rank increment.
module lfu_eval #(
	parameter int COUNT_BITS = 16,
	parameter int RANK_W     = 4
) (
	input  logic [lfu_pkg::KEY_W-1:0] rec_key,
	input  logic [lfu_pkg::KEY_W-1:0] key,
	input  logic [COUNT_BITS-1:0]     rec_cnt,
	input  logic [COUNT_BITS-1:0]     best_cnt,
	input  logic [RANK_W-1:0]         rec_rank,
	input  logic [RANK_W-1:0]         best_rank,
	input  logic [RANK_W-1:0]         limit,
	input  logic                      age_all,
	output lfu_pkg::eval_flags_t      flags,
	output logic [RANK_W-1:0]         rank_inc
);

	always_comb begin
		flags.key_eq  = (rec_key == key);
		// fewer uses wins; on equal use the older entry wins
		flags.better  = (rec_cnt < best_cnt) ||
		                ((rec_cnt == best_cnt) && (rec_rank > best_rank));
		flags.younger = age_all || (rec_rank < limit);
		rank_inc      = rec_rank + RANK_W'(1);
	end

endmodule
